### hdl/assert_macros.svh
// Assertion macros used by the engine RTL of the aging page replacement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define APR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in aging page replacement block");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define APR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in aging page replacement block");

`endif

### hdl/apr_pkg.sv
// Shared constants and types of the aging page replacement block.
`default_nettype none

package apr_pkg;

    localparam int FRAMES   = 16;
    localparam int AGE_BITS = 32;

    localparam int PAGE_W = 16;
    localparam int CFG_W  = 5;
    localparam int FI_W   = 4;
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    localparam logic [CFG_W-1:0]    CFG_RESET = CFG_W'(16);
    localparam logic [AGE_BITS-1:0] AGE_TOP   = AGE_BITS'(1) << (AGE_BITS - 1);

    typedef struct packed {
        logic              hit;
        logic [FI_W-1:0]   frame_index;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
    } apr_result_t;

endpackage

`default_nettype wire

### hdl/apr_if.sv
// Valid/ready channel interfaces for page references and their results.
`default_nettype none

interface apr_req_if;
    import apr_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_id;

    modport source (output valid, output page_id, input ready);
    modport sink (input valid, input page_id, output ready);
endinterface

interface apr_rsp_if;
    import apr_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [FI_W-1:0]   frame_index;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, input ready);
    modport sink (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, output ready);
endinterface

`default_nettype wire

### hdl/apr_engine.sv
// Frame table memories and the scan sequencer that ages, searches and updates them.
`default_nettype none
`include "assert_macros.svh"

module apr_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [apr_pkg::CFG_W-1:0]  cfg,
    input  wire logic                       start,
    input  wire logic [apr_pkg::PAGE_W-1:0] page_id,
    output logic                            idle,
    input  wire logic                       res_space,
    output logic                            res_fire,
    output apr_pkg::apr_result_t            res
);
    import apr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]    proc_idx_reg, proc_idx_next;
    logic                skip_reg, skip_next;
    logic                found_hit_reg, found_hit_next;
    logic                found_empty_reg, found_empty_next;
    logic [FRAMES-1:0]   valid_reg, valid_next;

    logic [PAGE_W-1:0]   id_reg, id_next;
    logic [IDX_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0]    empty_slot_reg, empty_slot_next;
    logic [IDX_W-1:0]    min_slot_reg, min_slot_next;
    logic [AGE_BITS-1:0] hit_age_reg, hit_age_next;
    logic [AGE_BITS-1:0] min_age_reg, min_age_next;
    logic [PAGE_W-1:0]   min_page_reg, min_page_next;

    logic [PAGE_W-1:0]   page_mem [FRAMES];
    logic [AGE_BITS-1:0] age_mem [FRAMES];
    logic [PAGE_W-1:0]   page_rdata_reg;
    logic [AGE_BITS-1:0] age_rdata_reg;
    logic [IDX_W-1:0]    raddr;
    logic                mem_we;
    logic [IDX_W-1:0]    waddr;
    logic [PAGE_W-1:0]   page_wdata;
    logic [AGE_BITS-1:0] age_wdata;

    logic [CNT_W-1:0]    n_eff;
    logic [PAGE_W-1:0]   eff_page;
    logic [AGE_BITS-1:0] aged;
    logic [IDX_W-1:0]    slot;
    logic                evict;

    // Clamp the frame count register into the range 1 .. FRAMES.
    always_comb
    begin
        if (cfg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(cfg) > FRAMES)
        begin
            n_eff = CNT_W'(FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(cfg);
        end
    end

    // A frame that was never written reads as empty with a zero counter.
    assign eff_page = valid_reg[proc_idx_reg] ? page_rdata_reg : '0;
    assign aged     = (valid_reg[proc_idx_reg] ? age_rdata_reg : '0) >> 1;
    assign raddr    = rd_cnt_reg[IDX_W-1:0];

    assign evict = !found_hit_reg && !found_empty_reg;
    assign slot  = found_hit_reg ? hit_slot_reg :
                   (found_empty_reg ? empty_slot_reg : min_slot_reg);
    assign idle  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        rd_cnt_next      = rd_cnt_reg;
        n_next           = n_reg;
        proc_valid_next  = proc_valid_reg;
        proc_idx_next    = proc_idx_reg;
        skip_next        = skip_reg;
        found_hit_next   = found_hit_reg;
        found_empty_next = found_empty_reg;
        valid_next       = valid_reg;
        id_next          = id_reg;
        hit_slot_next    = hit_slot_reg;
        empty_slot_next  = empty_slot_reg;
        min_slot_next    = min_slot_reg;
        hit_age_next     = hit_age_reg;
        min_age_next     = min_age_reg;
        min_page_next    = min_page_reg;
        mem_we           = 1'b0;
        waddr            = proc_idx_reg;
        page_wdata       = eff_page;
        age_wdata        = aged;
        res_fire         = 1'b0;
        res              = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    id_next          = page_id;
                    n_next           = n_eff;
                    skip_next        = (page_id == '0);
                    rd_cnt_next      = '0;
                    proc_valid_next  = 1'b0;
                    found_hit_next   = 1'b0;
                    found_empty_next = 1'b0;
                    state_next       = (page_id == '0) ? ST_FINAL : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (proc_valid_reg)
                begin
                    // Write the aged counter back and update the search trackers.
                    mem_we = 1'b1;
                    valid_next[proc_idx_reg] = 1'b1;
                    if (!found_hit_reg && (eff_page == id_reg))
                    begin
                        found_hit_next = 1'b1;
                        hit_slot_next  = proc_idx_reg;
                        hit_age_next   = aged;
                    end
                    if (!found_empty_reg && (eff_page == '0))
                    begin
                        found_empty_next = 1'b1;
                        empty_slot_next  = proc_idx_reg;
                    end
                    if ((proc_idx_reg == '0) || (aged < min_age_reg))
                    begin
                        min_age_next  = aged;
                        min_slot_next = proc_idx_reg;
                        min_page_next = eff_page;
                    end
                end
                if (rd_cnt_reg < n_reg)
                begin
                    proc_valid_next = 1'b1;
                    proc_idx_next   = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next     = rd_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    proc_valid_next = 1'b0;
                    state_next      = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (res_space)
                begin
                    res_fire   = 1'b1;
                    state_next = ST_IDLE;
                    if (!skip_reg)
                    begin
                        mem_we     = 1'b1;
                        waddr      = slot;
                        page_wdata = id_reg;
                        age_wdata  = found_hit_reg ? (hit_age_reg | AGE_TOP) : AGE_TOP;
                        valid_next[slot] = 1'b1;
                        res.hit           = found_hit_reg;
                        res.frame_index   = FI_W'(slot);
                        res.evicted_valid = evict;
                        res.evicted_page  = evict ? min_page_reg : '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[waddr] <= page_wdata;
            age_mem[waddr]  <= age_wdata;
        end
        page_rdata_reg <= page_mem[raddr];
        age_rdata_reg  <= age_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_cnt_reg      <= '0;
            n_reg           <= CNT_W'(1);
            proc_valid_reg  <= 1'b0;
            proc_idx_reg    <= '0;
            skip_reg        <= 1'b0;
            found_hit_reg   <= 1'b0;
            found_empty_reg <= 1'b0;
            valid_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_cnt_reg      <= rd_cnt_next;
            n_reg           <= n_next;
            proc_valid_reg  <= proc_valid_next;
            proc_idx_reg    <= proc_idx_next;
            skip_reg        <= skip_next;
            found_hit_reg   <= found_hit_next;
            found_empty_reg <= found_empty_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        hit_slot_reg   <= hit_slot_next;
        empty_slot_reg <= empty_slot_next;
        min_slot_reg   <= min_slot_next;
        hit_age_reg    <= hit_age_next;
        min_age_reg    <= min_age_next;
        min_page_reg   <= min_page_next;
    end

    // The frame being processed always lies inside the frames in use.
    `APR_ASSERT_NOW(a_proc_in_range, (state_reg == ST_SCAN) && proc_valid_reg,
                    {1'b0, proc_idx_reg} < n_reg)
    // The frame chosen for the update lies inside the frames in use.
    `APR_ASSERT_NOW(a_slot_in_range, res_fire && !skip_reg, {1'b0, slot} < n_reg)
    // Once a result leaves, the sequencer is ready for the next item.
    `APR_ASSERT_NEXT(a_done_idle, res_fire, state_reg == ST_IDLE)

endmodule

`default_nettype wire

### hdl/aging_page_replacement.sv
// Top level of the aging page replacement block: configuration, engine and result register.
`default_nettype none

// Aging page replacement table with up to FRAMES page frames. Each accepted item
// is a page reference; the block answers with exactly one result item that tells
// whether the page was resident, which frame now holds it, and which page, if any,
// was evicted. Every reference first ages the counters of all frames in use by one
// right shift; the referenced frame then gets the top counter bit, and on a miss
// with a full table the frame with the smallest counter (lowest index on a tie)
// is replaced. Page ids and counters live in two single-port-read memories that
// are scanned one frame per cycle over the frames in use, whose count is the
// clamped frames_in_use value; this rate is set by the one read port of the
// counter memory. A reference to page 0 changes nothing and completes with an
// all-zero result. Per-frame valid bits clear the table at reset, so there is
// no clearing pass and items are accepted right after reset. The frames_in_use
// register (reset 16) is written through cfg_we and cfg_wdata; the user must
// write it only while no item is in flight, as the block does not enforce it.
// A finished result waits in an output register, and the next item is accepted
// while it waits.
module aging_page_replacement (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [apr_pkg::CFG_W-1:0] cfg_wdata,
    apr_req_if.sink                        req,
    apr_rsp_if.source                      rsp
);
    import apr_pkg::*;

    logic [CFG_W-1:0] cfg_reg, cfg_next;
    logic             out_valid_reg, out_valid_next;
    apr_result_t      out_data_reg, out_data_next;

    logic             eng_idle;
    logic             res_space;
    logic             res_fire;
    apr_result_t      res;

    // The output register can take a result when it is empty or being drained.
    assign res_space = !out_valid_reg || rsp.ready;
    assign req.ready = eng_idle;

    apr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (req.valid),
        .page_id   (req.page_id),
        .idle      (eng_idle),
        .res_space (res_space),
        .res_fire  (res_fire),
        .res       (res)
    );

    always_comb
    begin
        cfg_next       = cfg_we ? cfg_wdata : cfg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_data_reg.hit;
    assign rsp.frame_index   = out_data_reg.frame_index;
    assign rsp.evicted_valid = out_data_reg.evicted_valid;
    assign rsp.evicted_page  = out_data_reg.evicted_page;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the aging page replacement block with its own table predictor.
`timescale 1ns / 1ps

module tb;
    import apr_pkg::*;

    // A generous ceiling on the run. The slowest correct run takes about 1000 items,
    // each a full scan of the frames in use, plus random stalls on both channels.
    localparam int CYCLE_LIMIT = 600000;

    // Cycles to let pass once the result queue is empty, well above the longest reference.
    localparam int SETTLE_CYCLES = 40;

    localparam int PHASE_ITEMS = 90;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    apr_req_if ref_bus();
    apr_rsp_if res_bus();

    aging_page_replacement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (ref_bus),
        .rsp       (res_bus)
    );

    always #4 clk = ~clk;

    // Page references waiting to be offered, and the results the table predictor
    // expects, oldest first.
    logic [PAGE_W-1:0] pending_refs[$];
    apr_result_t expected_results[$];

    // The predictor's private copy of the table and of the frames_in_use register.
    logic [PAGE_W-1:0]   page_tab[FRAMES];
    logic [AGE_BITS-1:0] age_tab[FRAMES];
    logic [CFG_W-1:0]    frames_cfg;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct;
    int recv_idle_pct;

    int error_count;
    int cycle_count;
    logic ref_taken;

    // The register value as the table sees it: zero acts as one frame, and
    // anything above the built depth acts as the full depth.
    function automatic int active_frames();
        if (frames_cfg == '0)
            return 1;
        if (int'(frames_cfg) > FRAMES)
            return FRAMES;
        return int'(frames_cfg);
    endfunction

    // Applies one page reference to the predicted table and returns the result
    // the block must produce for it.
    function automatic apr_result_t age_and_lookup(logic [PAGE_W-1:0] id);
        apr_result_t r;
        int n;
        int slot;
        bit found;
        r = '0;
        // A reference to page zero is ignored entirely.
        if (id == '0)
            return r;
        n = active_frames();
        // Every frame in use ages before the lookup, so the victim search sees
        // the aged counters.
        for (int i = 0; i < n; i++)
            age_tab[i] = age_tab[i] >> 1;
        found = 1'b0;
        slot = 0;
        // The lowest matching frame wins when an id is resident more than once.
        for (int i = 0; i < n && !found; i++)
        begin
            if (page_tab[i] == id)
            begin
                slot = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            age_tab[slot] = age_tab[slot] | AGE_TOP;
        end
        else
        begin
            for (int i = 0; i < n && !found; i++)
            begin
                if (page_tab[i] == '0)
                begin
                    slot = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                // Table full: the smallest counter goes, lowest index on a tie.
                slot = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (age_tab[i] < age_tab[slot])
                        slot = i;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = page_tab[slot];
            end
            page_tab[slot] = id;
            age_tab[slot] = AGE_TOP;
        end
        r.frame_index = slot[FI_W-1:0];
        return r;
    endfunction

    // Input side: an item is taken at a rising edge with valid and ready high.
    // Its prediction is made right there, so expectations keep acceptance order.
    always @(posedge clk)
    begin
        if (rst_n && ref_bus.valid && ref_bus.ready)
        begin
            expected_results.push_back(age_and_lookup(ref_bus.page_id));
            ref_taken <= 1'b1;
        end
        else
        begin
            ref_taken <= 1'b0;
        end
    end

    // Driver: changes the request channel at the falling edge. An item that has
    // not been taken yet stays on the bus unchanged; otherwise the next pending
    // item goes out unless the sender decides to hold back this cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            ref_bus.valid <= 1'b0;
        end
        else if (!(ref_bus.valid && !ref_taken))
        begin
            if (pending_refs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                ref_bus.valid <= 1'b1;
                ref_bus.page_id <= pending_refs.pop_front();
            end
            else
            begin
                // The bus carries junk while valid is low; the block must ignore it.
                ref_bus.valid <= 1'b0;
                ref_bus.page_id <= PAGE_W'($urandom);
            end
        end
    end

    // Receiver stalls are drawn fresh each cycle, so they land on every phase
    // of the block's work, including while a result sits in its output register.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
            res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: each result taken is compared field by field with the oldest
    // expectation. A result with nothing expected is a failure as well.
    always @(posedge clk)
    begin
        apr_result_t seen;
        apr_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            seen.hit = res_bus.hit;
            seen.frame_index = res_bus.frame_index;
            seen.evicted_valid = res_bus.evicted_valid;
            seen.evicted_page = res_bus.evicted_page;
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: hit=%0b frame=%0d evicted=%0b page=%h",
                             seen.hit, seen.frame_index, seen.evicted_valid,
                             seen.evicted_page);
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.hit !== want.hit || seen.frame_index !== want.frame_index ||
                    seen.evicted_valid !== want.evicted_valid ||
                    seen.evicted_page !== want.evicted_page)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $write("result mismatch: expected hit=%0b frame=%0d evicted=%0b ",
                               want.hit, want.frame_index, want.evicted_valid);
                        $display("page=%h, got hit=%0b frame=%0d evicted=%0b page=%h",
                                 want.evicted_page, seen.hit, seen.frame_index,
                                 seen.evicted_valid, seen.evicted_page);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Waits until every item has gone out and every result has come back, then
    // lets the block settle so that a register write finds it idle.
    task automatic wait_idle();
        while (pending_refs.size() != 0 || expected_results.size() != 0 || ref_bus.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes frames_in_use while the block is idle and mirrors it in the predictor.
    task automatic write_frames_cfg(logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        frames_cfg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= CFG_W'($urandom);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_cfg[10];
        logic [PAGE_W-1:0] pool_base;
        logic [PAGE_W-1:0] id;
        int span;
        int sel;

        ref_bus.valid = 1'b0;
        ref_bus.page_id = '0;
        res_bus.ready = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            page_tab[i] = '0;
            age_tab[i] = '0;
        end
        frames_cfg = CFG_RESET;
        error_count = 0;
        cycle_count = 0;
        ref_taken = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 65;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset setting of 16 frames. A zero id on the empty
        // table, the extreme ids, hits on recently filled frames, and a zero id
        // once the table holds pages.
        pending_refs.push_back(16'h0000);
        pending_refs.push_back(16'hFFFF);
        pending_refs.push_back(16'h0001);
        pending_refs.push_back(16'h8000);
        pending_refs.push_back(16'hAAAA);
        pending_refs.push_back(16'h5555);
        pending_refs.push_back(16'hFFFF);
        pending_refs.push_back(16'h0001);
        pending_refs.push_back(16'h0000);
        // Fill the rest of the table, then force an eviction and hit a late page.
        for (int i = 0; i < 11; i++)
            pending_refs.push_back(PAGE_W'(16'h0010 + i));
        pending_refs.push_back(16'h1234);
        pending_refs.push_back(16'h0010);

        // Shrink the table so a page resident in a high frame is outside the
        // range: it misses and gets a second copy in a low frame. Growing past
        // the depth again makes both copies visible, and the lower one must hit.
        write_frames_cfg(5'd2);
        pending_refs.push_back(16'h0019);
        write_frames_cfg(5'd31);
        pending_refs.push_back(16'h0019);

        // Random phases, each at its own setting. The register extremes (zero,
        // one, the depth, just above it and the top code) are all among them.
        phase_cfg = '{5'd0, 5'd1, 5'd16, 5'd3, 5'd17, 5'd8, 5'd31, 5'd2, 5'd12, 5'd0};
        phase_cfg[9] = CFG_W'($urandom_range(0, 31));
        pool_base = 16'h0100;
        for (int p = 0; p < 10; p++)
        begin
            write_frames_cfg(phase_cfg[p]);
            if (p < 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 65;
            end
            else if (p < 6)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // The working set changes only every other phase, so pages left in
            // frames outside a small range come back into use with duplicates.
            if (p % 2 == 0)
                pool_base = PAGE_W'($urandom_range(1, 65535 - 40));
            // A working set a little larger than the table gives a mix of hits,
            // fills and evictions, with counters aging down to ties.
            span = active_frames() + $urandom_range(0, 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(99);
                if (sel < 6)
                    id = '0;
                else if (sel < 18)
                    id = PAGE_W'($urandom_range(1, 65535));
                else
                    id = pool_base + PAGE_W'($urandom_range(0, span - 1));
                pending_refs.push_back(id);
            end
        end

        wait_idle();
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/apr_pkg.sv
hdl/apr_if.sv
hdl/apr_engine.sv
hdl/aging_page_replacement.sv
tb/tb.sv
